[hw/rtl/selu_pkg.sv]
`default_nettype none

package selu_pkg;

   // Number formats
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;

   // Exp table: EXP_TABLE_ENTRIES samples of 2^(-k/N) in Q16, plus one guard entry
   localparam int EXP_TABLE_ENTRIES = 64;
   localparam int TAB_DEPTH         = EXP_TABLE_ENTRIES + 1;
   localparam int TAB_AW            = $clog2(TAB_DEPTH);
   localparam int TAYLOR_TERMS      = 24;

   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [63:0] LN2_Q30   = 64'd744261118;

   // Saturation magnitudes for the signed result
   localparam logic [63:0] SAT_POS_MAG = 64'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic [63:0] SAT_NEG_MAG = 64'd1 << (DATA_WIDTH - 1);

   // Register file
   localparam int          CSR_AW       = 3;
   localparam logic        CSR_ALPHA    = 1'b0;
   localparam logic        CSR_LAMBDA   = 1'b1;
   localparam logic [15:0] ALPHA_RESET  = 16'd6854;
   localparam logic [15:0] LAMBDA_RESET = 16'd4304;

   // Per-item control that travels down the pipe
   typedef struct packed {
      logic        valid;
      logic        back;   // backward gradient
      logic        pos;    // activation strictly positive
      logic        neg;    // sign of the final result
      logic [15:0] mag;    // magnitude of x or of the error
   } item_type;

   // One table entry, evaluated at elaboration only.
   // The guard entry past the end is half of entry zero.
   function automatic logic [16:0] exp_entry(input int unsigned k);
      logic [63:0] y;
      logic [63:0] term;
      logic [63:0] s;
      logic [16:0] ent;
      int unsigned kk;
      kk   = (k == EXP_TABLE_ENTRIES) ? 0 : k;
      y    = (64'(kk) * LN2_Q30 + 64'(EXP_TABLE_ENTRIES / 2)) / 64'(EXP_TABLE_ENTRIES);
      term = 64'd1 << 30;
      s    = 64'd1 << 30;
      for (int i = 1; i <= TAYLOR_TERMS; i++) begin
         term = ((term * y) >> 30) / 64'(i);
         if (i[0]) begin
            s = s - term;
         end else begin
            s = s + term;
         end
      end
      ent = 17'((s + 64'd8192) >> 14);
      return (k == EXP_TABLE_ENTRIES) ? (ent >> 1) : ent;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/selu_csr.sv]
`default_nettype none

module selu_csr import selu_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready,
   output logic      [15:0]       lambda_out,
   output logic      [31:0]       la_out
);

   logic [15:0] alpha_ff, alpha_in;
   logic [15:0] lambda_ff, lambda_in;
   logic [31:0] la_ff, la_in;
   logic        wr_xfer;
   logic        reg_sel;

   assign pready  = 1'b1;
   assign wr_xfer = psel & penable & pwrite & pready;
   assign reg_sel = paddr[2];

   // Register writes
   always_comb begin
      alpha_in  = alpha_ff;
      lambda_in = lambda_ff;
      if (wr_xfer) begin
         unique case (reg_sel)
            CSR_ALPHA:  alpha_in  = pwdata[15:0];
            CSR_LAMBDA: lambda_in = pwdata[15:0];
            default:    alpha_in  = alpha_ff;
         endcase
      end
   end

   // lambda*alpha product, kept current from the registers (Q8.24)
   assign la_in = 32'(alpha_ff) * 32'(lambda_ff);

   always_ff @(posedge clock) begin
      la_ff <= la_in;
      if (reset) begin
         alpha_ff  <= ALPHA_RESET;
         lambda_ff <= LAMBDA_RESET;
      end else begin
         alpha_ff  <= alpha_in;
         lambda_ff <= lambda_in;
      end
   end

   // Read back
   assign prdata     = {16'd0, (reg_sel == CSR_LAMBDA) ? lambda_ff : alpha_ff};
   assign lambda_out = lambda_ff;
   assign la_out     = la_ff;

endmodule

`default_nettype wire

[hw/rtl/selu_exp.sv]
`default_nettype none

// exp(-n) = 2^-u: table lookup, interpolation, then the integer-part shift.
// Three register stages; the item control rides along.
module selu_exp import selu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire item_type    item_in,
   input  wire logic [15:0] u_in,
   output item_type         item_out,
   output logic      [16:0] e_out
);

   localparam int POS_W = FRAC_BITS + TAB_AW;

   // Constant table
   logic [16:0] exp_tab [TAB_DEPTH];
   for (genvar k = 0; k < TAB_DEPTH; k++) begin : g_tab
      assign exp_tab[k] = exp_entry(k);
   end

   // Stage A: split u, look up both neighbors
   logic [3:0]           ip;
   logic [FRAC_BITS-1:0] frac;
   logic [POS_W-1:0]     tpos;
   logic [TAB_AW-1:0]    idx_a, idx_b;
   logic [16:0]          tab_a, tab_b;

   assign ip    = u_in[15:12];
   assign frac  = u_in[FRAC_BITS-1:0];
   assign tpos  = POS_W'(frac) * POS_W'(EXP_TABLE_ENTRIES);
   assign idx_a = tpos[POS_W-1:FRAC_BITS];
   assign idx_b = idx_a + TAB_AW'(1);
   assign tab_a = exp_tab[idx_a];
   assign tab_b = exp_tab[idx_b];

   item_type             item_a_ff;
   logic [16:0]          a_ff, d_ff;
   logic [FRAC_BITS-1:0] r_ff;
   logic [3:0]           ip_a_ff;

   always_ff @(posedge clock) begin
      a_ff    <= tab_a;
      d_ff    <= tab_a - tab_b;
      r_ff    <= tpos[FRAC_BITS-1:0];
      ip_a_ff <= ip;
      if (reset) begin
         item_a_ff <= '0;
      end else begin
         item_a_ff <= item_in;
      end
   end

   // Stage B: linear interpolation, rounded
   logic [29:0] step;
   logic [16:0] v_in;

   assign step = (30'(d_ff) * 30'(r_ff) + 30'd2048) >> FRAC_BITS;
   assign v_in = a_ff - 17'(step);

   item_type    item_b_ff;
   logic [16:0] v_ff;
   logic [3:0]  ip_b_ff;

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      ip_b_ff <= ip_a_ff;
      if (reset) begin
         item_b_ff <= '0;
      end else begin
         item_b_ff <= item_a_ff;
      end
   end

   // Stage C: integer part as a rounded right shift
   logic [17:0] rnd;
   logic [16:0] e_in;

   assign rnd  = (ip_b_ff == 4'd0) ? 18'd0 : (18'd1 << (ip_b_ff - 4'd1));
   assign e_in = 17'((18'(v_ff) + rnd) >> ip_b_ff);

   item_type    item_c_ff;
   logic [16:0] e_ff;

   always_ff @(posedge clock) begin
      e_ff <= e_in;
      if (reset) begin
         item_c_ff <= '0;
      end else begin
         item_c_ff <= item_b_ff;
      end
   end

   assign item_out = item_c_ff;
   assign e_out    = e_ff;

endmodule

`default_nettype wire

[hw/rtl/selu_scale.sv]
`default_nettype none

// Gain products, rounding to Q12 and saturation. Four register stages.
module selu_scale import selu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire item_type    item_in,
   input  wire logic [16:0] e_in,
   input  wire logic [15:0] lambda,
   input  wire logic [31:0] la,
   output logic             rsp_strobe,
   output logic      [15:0] rsp_result_value,
   output logic             rsp_saturated
);

   localparam int SHIFT_LIN = 12;
   localparam int SHIFT_FWD = 28;
   localparam int SHIFT_BWD = 40;

   // Stage 1: one shared 32x17 multiply
   //   positive x:         lambda * |v|
   //   forward, x <= 0:    lambda*alpha * (1 - e)
   //   backward, x <= 0:   |err| * e  (lambda*alpha applied next)
   logic [16:0] m1;
   logic [31:0] mul_a;
   logic [16:0] mul_b;

   assign m1 = 17'(18'd65536 - 18'(e_in));

   always_comb begin
      if (item_in.pos) begin
         mul_a = 32'(lambda);
         mul_b = 17'(item_in.mag);
      end else if (!item_in.back) begin
         mul_a = la;
         mul_b = m1;
      end else begin
         mul_a = 32'(item_in.mag);
         mul_b = e_in;
      end
   end

   item_type    item_p_ff;
   logic [48:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= 49'(mul_a) * 49'(mul_b);
      if (reset) begin
         item_p_ff <= '0;
      end else begin
         item_p_ff <= item_in;
      end
   end

   // Stage 2: backward product times lambda*alpha, in a 17-bit low half and a 16-bit high half
   logic        bwd;
   logic [32:0] me;
   logic [48:0] lo_in;
   logic [47:0] hi_in;

   assign bwd   = item_p_ff.back & ~item_p_ff.pos;
   assign me    = p_ff[32:0];
   assign lo_in = bwd ? 49'(la) * 49'(me[16:0]) : p_ff;
   assign hi_in = bwd ? 48'(la) * 48'(me[32:17]) : 48'd0;

   item_type    item_h_ff;
   logic [48:0] lo_ff;
   logic [47:0] hi_ff;

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (reset) begin
         item_h_ff <= '0;
      end else begin
         item_h_ff <= item_p_ff;
      end
   end

   // Stage 3: recombine the halves
   item_type    item_f_ff;
   logic [63:0] full_ff;

   always_ff @(posedge clock) begin
      full_ff <= 64'({hi_ff, 17'd0}) + 64'(lo_ff);
      if (reset) begin
         item_f_ff <= '0;
      end else begin
         item_f_ff <= item_h_ff;
      end
   end

   // Stage 4: round half away from zero, clamp, apply sign
   logic [63:0] q;
   logic [63:0] limit;
   logic        sat;
   logic [15:0] q_mag;
   logic [15:0] res;

   always_comb begin
      if (item_f_ff.pos) begin
         q = (full_ff + (64'd1 << (SHIFT_LIN - 1))) >> SHIFT_LIN;
      end else if (item_f_ff.back) begin
         q = (full_ff + (64'd1 << (SHIFT_BWD - 1))) >> SHIFT_BWD;
      end else begin
         q = (full_ff + (64'd1 << (SHIFT_FWD - 1))) >> SHIFT_FWD;
      end
   end

   assign limit = item_f_ff.neg ? SAT_NEG_MAG : SAT_POS_MAG;
   assign sat   = (q > limit);
   assign q_mag = sat ? 16'(limit) : 16'(q);
   assign res   = item_f_ff.neg ? 16'(~q_mag + 16'd1) : q_mag;

   logic        strobe_ff;
   logic [15:0] res_ff;
   logic        sat_ff;

   always_ff @(posedge clock) begin
      res_ff <= res;
      sat_ff <= sat;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= item_f_ff.valid;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_result_value = res_ff;
   assign rsp_saturated    = sat_ff;

endmodule

`default_nettype wire

[hw/rtl/selu_activation_and_gradient.sv]
// Results: each accepted item shows its result on the rsp_ ports for one cycle.
// Throughput: one item per cycle; eight register stages, busy stays low.
// Reset (synchronous, active high) empties the pipe and loads alpha and lambda
//   with their defaults; results are never held off by the receiver.
`default_nettype none

module selu_activation_and_gradient import selu_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   // command channel
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_operation,
   input  wire logic signed [15:0] req_act_value,
   input  wire logic signed [15:0] req_err_value,
   // result channel
   output logic                    rsp_strobe,
   output logic signed      [15:0] rsp_result_value,
   output logic                    rsp_saturated,
   // register port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [CSR_AW-1:0]  paddr,
   input  wire logic [31:0]        pwdata,
   output logic      [31:0]        prdata,
   output logic                    pready
);

   logic [15:0] lambda;
   logic [31:0] la;

   selu_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .lambda_out (lambda),
      .la_out     (la)
   );

   // Input stage: classify, take magnitudes, form u = |x|*log2(e) in Q12
   logic        xfer;
   logic        x_pos;
   logic [15:0] n_mag;
   logic        err_neg;
   logic [15:0] err_mag;
   logic [32:0] u_prod;
   logic [15:0] u_in;
   item_type    item_in;

   assign busy    = 1'b0;
   assign xfer    = start & ~busy;
   assign x_pos   = (req_act_value > 16'sd0);
   assign n_mag   = 16'(~req_act_value) + 16'd1;
   assign err_neg = req_err_value[15];
   assign err_mag = err_neg ? (16'(~req_err_value) + 16'd1) : 16'(req_err_value);
   assign u_prod  = 33'(n_mag) * 33'(LOG2E_Q16);
   assign u_in    = 16'((u_prod + 33'd32768) >> 16);

   always_comb begin
      item_in.valid = xfer;
      item_in.back  = req_operation;
      item_in.pos   = x_pos;
      if (x_pos && !req_operation) begin
         item_in.neg = 1'b0;
         item_in.mag = 16'(req_act_value);
      end else if (req_operation) begin
         item_in.neg = err_neg;
         item_in.mag = err_mag;
      end else begin
         // forward with x <= 0: lambda*alpha*(e-1) is never positive
         item_in.neg = 1'b1;
         item_in.mag = err_mag;
      end
   end

   item_type    item_ff;
   logic [15:0] u_ff;

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      if (reset) begin
         item_ff <= '0;
      end else begin
         item_ff <= item_in;
      end
   end

   // exp of the non-positive activation
   item_type    item_e;
   logic [16:0] e_val;

   selu_exp u_exp (
      .clock    (clock),
      .reset    (reset),
      .item_in  (item_ff),
      .u_in     (u_ff),
      .item_out (item_e),
      .e_out    (e_val)
   );

   // gains, rounding, saturation, output register
   logic [15:0] res_bits;

   selu_scale u_scale (
      .clock            (clock),
      .reset            (reset),
      .item_in          (item_e),
      .e_in             (e_val),
      .lambda           (lambda),
      .la               (la),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (res_bits),
      .rsp_saturated    (rsp_saturated)
   );

   assign rsp_result_value = res_bits;

endmodule

`default_nettype wire

[hw/rtl/selu_checker.sv]
`default_nettype none

module selu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire logic [15:0] rsp_result_value,
   input wire logic        rsp_saturated
);

   // the block always takes commands
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   // every accepted command yields a result after the pipe delay
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##8 rsp_strobe)
      else $error("result missing for accepted command");

   // no result without an earlier accepted command
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 8))
      else $error("result without command");

   // a clipped result sits at one of the range limits
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_saturated |->
         (rsp_result_value == 16'h7fff || rsp_result_value == 16'h8000))
      else $error("saturated result not at a limit");

   // the pipe is empty right after a reset edge
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result right after reset");

endmodule

bind selu_activation_and_gradient selu_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_result_value (rsp_result_value),
   .rsp_saturated    (rsp_saturated)
);

`default_nettype wire

[test/selu_tb_pkg.sv]
package selu_tb_pkg;

   // Operation carried by each command transfer
   typedef enum logic {
      OP_FORWARD  = 1'b0,
      OP_BACKWARD = 1'b1
   } selu_op_type;

endpackage

[test/selu_checker.sv]
module selu_scoreboard import selu_pkg::*; import selu_tb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic                    req_operation,
   input  logic signed [15:0]      req_act_value,
   input  logic signed [15:0]      req_err_value,
   input  logic                    rsp_strobe,
   input  logic signed [15:0]      rsp_result_value,
   input  logic                    rsp_saturated,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_AW-1:0]       paddr,
   input  logic [31:0]             pwdata,
   input  logic                    pready,
   output int                      mismatches,
   output int                      outstanding,
   output int                      checked,
   output int                      clipped
);

   typedef longint unsigned u64_type;

   localparam int      TAB_N      = 64;
   localparam u64_type LOG2E_Q16C = 64'd94548;
   localparam u64_type LN2_Q30C   = 64'd744261118;
   localparam int      TERMS      = 24;
   localparam int      REPORT_MAX = 10;

   // One predicted result plus the command that caused it
   typedef struct {
      selu_op_type        op;
      logic signed [15:0] act;
      logic signed [15:0] err;
      logic signed [15:0] value;
      logic               clip;
   } selu_out_type;

   u64_type      pow2_frac [0:TAB_N];
   logic [15:0]  alpha_q;
   logic [15:0]  lambda_q;
   selu_out_type queued_results [$];

   // 2^(-k/N) in Q16 from a truncated series of exp(-k*ln2/N); guard entry is half of entry 0
   function automatic void build_pow2_table();
      u64_type y;
      u64_type term;
      longint  s;
      for (int k = 0; k < TAB_N; k++) begin
         y    = (u64_type'(k) * LN2_Q30C + u64_type'(TAB_N / 2)) / u64_type'(TAB_N);
         term = u64_type'(1) << 30;
         s    = longint'(1) << 30;
         for (int i = 1; i <= TERMS; i++) begin
            term = ((term * y) >> 30) / u64_type'(i);
            if (i % 2 == 1) begin
               s -= longint'(term);
            end else begin
               s += longint'(term);
            end
         end
         pow2_frac[k] = (u64_type'(s) + 64'd8192) >> 14;
      end
      pow2_frac[TAB_N] = pow2_frac[0] >> 1;
   endfunction

   // exp(-n/4096) in Q16: integer part of n*log2e is a shift, fraction is interpolated
   function automatic u64_type exp_neg_q16(int unsigned n);
      u64_type     u;
      u64_type     f;
      u64_type     pos;
      u64_type     r;
      u64_type     a;
      u64_type     b;
      u64_type     v;
      int unsigned ip;
      int unsigned idx;
      u   = (u64_type'(n) * LOG2E_Q16C + 64'd32768) >> 16;
      ip  = int'(u >> 12);
      f   = u & 64'd4095;
      pos = f * u64_type'(TAB_N);
      idx = int'(pos >> 12);
      r   = pos & 64'd4095;
      a   = pow2_frac[idx];
      b   = pow2_frac[idx + 1];
      v   = a - (((a - b) * r + 64'd2048) >> 12);
      if (ip > 0) begin
         if (ip > 62) begin
            v = 0;
         end else begin
            v = (v + (u64_type'(1) << (ip - 1))) >> ip;
         end
      end
      return v;
   endfunction

   // Magnitude shift with half rounded away from zero, then sign applied
   function automatic longint round_shift(bit neg, u64_type mag, int sh);
      u64_type q;
      q = (mag + (u64_type'(1) << (sh - 1))) >> sh;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic selu_out_type selu_predict(selu_op_type op, logic signed [15:0] act,
                                                 logic signed [15:0] err);
      selu_out_type o;
      int           xi;
      int           vi;
      bit           neg;
      u64_type      mag;
      u64_type      e;
      u64_type      lam;
      u64_type      alp;
      longint       res;
      xi     = act;
      lam    = u64_type'(lambda_q);
      alp    = u64_type'(alpha_q);
      o.op   = op;
      o.act  = act;
      o.err  = err;
      o.clip = 1'b0;
      if (xi > 0) begin
         // positive side: plain lambda scale
         vi  = (op == OP_BACKWARD) ? int'(err) : xi;
         neg = vi < 0;
         mag = u64_type'(neg ? -vi : vi);
         res = round_shift(neg, lam * mag, 12);
      end else begin
         // non-positive side, zero included
         e = exp_neg_q16(unsigned'(-xi));
         if (op == OP_FORWARD) begin
            res = round_shift(1'b1, lam * alp * (64'd65536 - e), 28);
         end else begin
            vi  = err;
            neg = vi < 0;
            mag = u64_type'(neg ? -vi : vi);
            res = round_shift(neg, lam * alp * mag * e, 40);
         end
      end
      if (res > 32767) begin
         res    = 32767;
         o.clip = 1'b1;
      end
      if (res < -32768) begin
         res    = -32768;
         o.clip = 1'b1;
      end
      o.value = 16'(res);
      return o;
   endfunction

   initial begin
      mismatches  = 0;
      outstanding = 0;
      checked     = 0;
      clipped     = 0;
      alpha_q     = ALPHA_RESET;
      lambda_q    = LAMBDA_RESET;
      build_pow2_table();
   end

   always @(posedge clock) begin
      selu_out_type want;
      if (reset) begin
         alpha_q  = ALPHA_RESET;
         lambda_q = LAMBDA_RESET;
         queued_results.delete();
      end else begin
         // register write transfer
         if (psel && penable && pwrite && pready) begin
            if (paddr[CSR_AW-1:2] == CSR_ALPHA) begin
               alpha_q = pwdata[15:0];
            end else if (paddr[CSR_AW-1:2] == CSR_LAMBDA) begin
               lambda_q = pwdata[15:0];
            end
         end

         // result transfer against the oldest prediction
         if (rsp_strobe) begin
            checked++;
            if (rsp_saturated) clipped++;
            if (queued_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected result: value %0d clip %0b", rsp_result_value,
                           rsp_saturated);
            end else begin
               want = queued_results.pop_front();
               if (rsp_result_value !== want.value || rsp_saturated !== want.clip) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("mismatch %s act %0d err %0d:", want.op.name(), want.act,
                              want.err);
                     $display("  value exp %0d got %0d, clip exp %0b got %0b",
                              want.value, rsp_result_value, want.clip, rsp_saturated);
                  end
               end
            end
         end

         // command transfer
         if (start && !busy)
            queued_results.push_back(selu_predict(selu_op_type'(req_operation),
                                                  req_act_value, req_err_value));
      end
      outstanding = queued_results.size();
   end

endmodule

[test/tb.sv]
module tb import selu_pkg::*; import selu_tb_pkg::*;;

   localparam int PIPE_DEPTH   = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 235;
   localparam logic [CSR_AW-1:0] ADDR_ALPHA  = {CSR_ALPHA, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_LAMBDA = {CSR_LAMBDA, 2'b00};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_operation = 1'b0;
   logic signed [15:0] req_act_value = '0;
   logic signed [15:0] req_err_value = '0;
   logic               rsp_strobe;
   logic signed [15:0] rsp_result_value;
   logic               rsp_saturated;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [CSR_AW-1:0]  paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   int mismatches;
   int outstanding;
   int checked;
   int clipped;
   int cycles = 0;
   int idle_pct = 32;
   int fwd_sent = 0;
   int bwd_sent = 0;
   int gain_sets = 1;

   selu_activation_and_gradient uut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_operation(req_operation), .req_act_value(req_act_value),
      .req_err_value(req_err_value),
      .rsp_strobe(rsp_strobe), .rsp_result_value(rsp_result_value),
      .rsp_saturated(rsp_saturated),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   selu_scoreboard selu_check (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_operation(req_operation), .req_act_value(req_act_value),
      .req_err_value(req_err_value),
      .rsp_strobe(rsp_strobe), .rsp_result_value(rsp_result_value),
      .rsp_saturated(rsp_saturated),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .mismatches(mismatches), .outstanding(outstanding),
      .checked(checked), .clipped(clipped)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
         $display("== FAIL ==");
         $finish;
      end
   end

   // random idle cycles on the command side
   task automatic idle_gap();
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_item(input selu_op_type op, input logic signed [15:0] act,
                            input logic signed [15:0] err);
      start         <= 1'b1;
      req_operation <= op;
      req_act_value <= act;
      req_err_value <= err;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op == OP_FORWARD) fwd_sent++;
      else bwd_sent++;
      idle_gap();
   endtask

   task automatic send_random();
      int          xi;
      int          ei;
      selu_op_type op;
      op = $urandom_range(1) ? OP_BACKWARD : OP_FORWARD;
      case ($urandom_range(9))
         0, 1, 2, 3: xi = int'($urandom_range(65535)) - 32768;
         4, 5, 6:    xi = -int'($urandom_range(32768));
         7:          xi = int'($urandom_range(80)) - 40;
         8:          xi = $urandom_range(1) ? 32767 : -32768;
         default:    xi = int'($urandom_range(8192));
      endcase
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(3))
               0:       ei = 32767;
               1:       ei = -32768;
               2:       ei = 0;
               default: ei = -1;
            endcase
         end
         default: ei = int'($urandom_range(65535)) - 32768;
      endcase
      send_item(op, 16'(xi), 16'(ei));
   endtask

   // stop commands and wait for every predicted result to come back
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   // setup then access cycle; upper data bits are junk the block must drop
   task automatic write_gain(input logic [CSR_AW-1:0] addr, input logic [15:0] gain);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {16'($urandom), gain};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_gains(input logic [15:0] alpha, input logic [15:0] lambda);
      settle();
      write_gain(ADDR_ALPHA, alpha);
      write_gain(ADDR_LAMBDA, lambda);
      gain_sets++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero activation, unit steps, field extremes, clipping, ignored error
      send_item(OP_FORWARD,  16'sd0,      16'sh1234);
      send_item(OP_BACKWARD, 16'sd0,      16'sd1000);
      send_item(OP_FORWARD,  16'sd1,      16'sd0);
      send_item(OP_BACKWARD, 16'sd1,      -16'sd1);
      send_item(OP_FORWARD,  -16'sd1,     16'sd32767);
      send_item(OP_BACKWARD, -16'sd1,     16'sd32767);
      send_item(OP_FORWARD,  16'sd32767,  -16'sd32768);
      send_item(OP_BACKWARD, 16'sd32767,  16'sd32767);
      send_item(OP_BACKWARD, 16'sd32767,  -16'sd32768);
      send_item(OP_FORWARD,  -16'sd32768, 16'sd0);
      send_item(OP_BACKWARD, -16'sd32768, -16'sd32768);
      send_item(OP_BACKWARD, -16'sd32768, 16'sd32767);
      send_item(OP_BACKWARD, 16'sd0,      16'sd32767);
      send_item(OP_BACKWARD, 16'sd0,      -16'sd32768);
      send_item(OP_FORWARD,  16'sd4096,   16'sd0);
      send_item(OP_FORWARD,  -16'sd4096,  -16'sd1);
      send_item(OP_BACKWARD, -16'sd4096,  16'sd4096);
      send_item(OP_BACKWARD, 16'sd4096,   -16'sd4096);
      send_item(OP_FORWARD,  -16'sd2839,  16'sd0);
      send_item(OP_BACKWARD, -16'sd64,    16'sd0);

      // random phases under several gain settings; the first and last use the defaults
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: ;
            1: load_gains(16'd0, 16'd0);
            2: load_gains(16'hFFFF, 16'hFFFF);
            3: load_gains(16'hFFFF, 16'd0);
            4: load_gains(16'd0, 16'hFFFF);
            5, 6: load_gains(16'($urandom), 16'($urandom));
            default: load_gains(ALPHA_RESET, LAMBDA_RESET);
         endcase
         // one phase streams back to back
         idle_pct = (p == 3) ? 0 : 32;
         for (int n = 0; n < PHASE_ITEMS; n++) send_random();
      end

      settle();
      $display("covered %0d forward and %0d backward items under %0d gain settings",
               fwd_sent, bwd_sent, gain_sets);
      $display("%0d results compared, %0d clipped, %0d mismatches, %0d missing",
               checked, clipped, mismatches, outstanding);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
